// ----- hdl/ps2md_pkg.sv -----
// Package for the PS/2 mouse packet decoder: event codes, the packet
// descriptor passed from front to back, and queue sizing.
// No dependencies.
`default_nettype none

package ps2md_pkg;

	// status bit that flags a valid auxiliary data byte
	localparam int unsigned AUX_VALID_BIT = 5;
	// bytes in one mouse packet
	localparam int unsigned PACKET_LEN    = 3;
	localparam int unsigned SLOT_W        = $clog2(PACKET_LEN);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PACKET_LEN - 1);
	// buttons carried in packet byte 0
	localparam int unsigned NUM_BUTTONS   = 3;

	// descriptor queue between front and back
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		EV_MOVE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} ev_kind_t;

	// one completed packet that yields at least one event
	typedef struct packed {
		logic                          move;
		logic signed [7:0]             dx;
		logic signed [8:0]             dy;
		logic [NUM_BUTTONS-1:0]        chg;
		logic [NUM_BUTTONS-1:0]        prev;
	} pkt_desc_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- hdl/ps2md_front.sv -----
// Front end: takes input words, assembles three-byte packets, keeps the
// button state and the consumer_attached register. Uses ps2md_pkg.
`default_nettype none

module ps2md_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           status_byte,
	input  wire logic [7:0]           data_byte,
	// configuration write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_data,
	// descriptor queue write side
	input  wire ps2md_pkg::q_status_t q_stat,
	output logic                      q_push,
	output ps2md_pkg::pkt_desc_t      q_desc
);
	import ps2md_pkg::*;

	logic                   consumer_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [7:0]             byte0_q;
	logic [7:0]             byte1_q;
	logic [NUM_BUTTONS-1:0] buttons_q;

	logic                   accept;
	logic                   aux_ok;
	logic                   complete;
	logic [NUM_BUTTONS-1:0] new_buttons;
	logic signed [8:0]      y9;

	assign in_ready  = !q_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign aux_ok    = status_byte[AUX_VALID_BIT];
	assign complete  = accept && aux_ok && consumer_q && (slot_q == LAST_SLOT);

	// descriptor for the packet closed by this word (byte 2 is data_byte)
	always_comb begin
		new_buttons  = byte0_q[NUM_BUTTONS-1:0];
		y9           = {data_byte[7], data_byte};
		q_desc.move  = (byte1_q != 8'd0) || (data_byte != 8'd0);
		q_desc.dx    = byte1_q;
		q_desc.dy    = -y9;
		q_desc.chg   = new_buttons ^ buttons_q;
		q_desc.prev  = buttons_q;
		q_push       = complete && (q_desc.move || (q_desc.chg != '0));
	end

	// consumer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumer_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			consumer_q <= cfg_data;
		end
	end

	// slot and button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			buttons_q <= '0;
		end else if (accept && aux_ok && consumer_q) begin
			if (slot_q == LAST_SLOT) begin
				slot_q    <= '0;
				buttons_q <= new_buttons;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	// packet byte store; byte 2 is used straight from the input
	always_ff @(posedge clk) begin
		if (accept && aux_ok) begin
			if (slot_q == '0) byte0_q <= data_byte;
			if (slot_q == SLOT_W'(1)) byte1_q <= data_byte;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ps2md_fifo.sv -----
// Short descriptor queue between front and back ends.
// Uses ps2md_pkg for the descriptor type and depth.
`default_nettype none

module ps2md_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ps2md_pkg::pkt_desc_t wr_desc,
	input  wire logic                 pop,
	output ps2md_pkg::pkt_desc_t      rd_desc,
	output ps2md_pkg::q_status_t      stat
);
	import ps2md_pkg::*;

	pkt_desc_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_desc    = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + QPTR_W'(1);
		return r;
	endfunction

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_desc;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("descriptor queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("descriptor queue underflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ----- hdl/ps2md_back.sv -----
// Back end: expands each packet descriptor into move and button events,
// one per cycle while out_ready is high, registered. Uses ps2md_pkg.
`default_nettype none

module ps2md_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// descriptor queue read side
	input  wire ps2md_pkg::q_status_t q_stat,
	input  wire ps2md_pkg::pkt_desc_t q_desc,
	output logic                      q_pop,
	// event words
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                event_kind,
	output logic signed [7:0]         delta_x,
	output logic signed [8:0]         delta_y,
	output logic [1:0]                button_number,
	output logic                      last_event
);
	import ps2md_pkg::*;

	localparam int unsigned MASK_W = NUM_BUTTONS + 1;

	// pending events of the packet in progress: bit 0 move, bits 1.. buttons
	logic [MASK_W-1:0]      rem_q;
	logic [NUM_BUTTONS-1:0] prev_q;

	logic                   out_valid_q;
	ev_kind_t               kind_q;
	logic signed [7:0]      dx_q;
	logic signed [8:0]      dy_q;
	logic [1:0]             btn_q;
	logic                   last_q;

	logic                   advance;
	logic                   rem_nz;
	logic                   produce;
	logic [MASK_W-1:0]      src_mask;
	logic [MASK_W-1:0]      pick;
	logic [MASK_W-1:0]      rest;
	logic [NUM_BUTTONS-1:0] src_prev;
	ev_kind_t               nx_kind;
	logic [1:0]             nx_btn;

	assign advance = !out_valid_q || out_ready;
	assign rem_nz  = (rem_q != '0);
	assign produce = advance && (rem_nz || !q_stat.empty);
	assign q_pop   = advance && !rem_nz && !q_stat.empty;

	// pick the lowest pending event
	always_comb begin
		src_mask = rem_nz ? rem_q : {q_desc.chg, q_desc.move};
		src_prev = rem_nz ? prev_q : q_desc.prev;
		pick     = src_mask & (~src_mask + MASK_W'(1));
		rest     = src_mask & ~pick;
		nx_kind  = EV_MOVE;
		nx_btn   = 2'd0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (pick[i+1]) begin
				nx_kind = src_prev[i] ? EV_RELEASE : EV_PRESS;
				nx_btn  = 2'(i + 1);
			end
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
			if (produce) rem_q <= rest;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (q_pop) prev_q <= q_desc.prev;
		if (produce) begin
			kind_q <= nx_kind;
			btn_q  <= nx_btn;
			last_q <= (rest == '0);
			dx_q   <= pick[0] ? q_desc.dx : 8'sd0;
			dy_q   <= pick[0] ? q_desc.dy : 9'sd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign delta_x       = dx_q;
	assign delta_y       = dy_q;
	assign button_number = btn_q;
	assign last_event    = last_q;

	// move always goes out straight from the queue head, never held
	a_move_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		!rem_q[0])
		else $error("move event left pending");

	a_move_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == EV_MOVE) |-> (btn_q == 2'd0))
		else $error("move event carries a button number");

	a_button_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != EV_MOVE) |->
		(dx_q == 8'sd0 && dy_q == 9'sd0 && btn_q != 2'd0))
		else $error("button event fields wrong");

	a_pending_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rem_nz) |-> !last_q)
		else $error("last flag set with events pending");

endmodule

`default_nettype wire

// ----- hdl/ps2_mouse_packet_decoder.sv -----
// PS/2 mouse packet decoder, top level.
// Depends on ps2md_pkg, ps2md_front, ps2md_fifo and ps2md_back.
//
// Input channel (in_valid/in_ready, status_byte, data_byte): one status
// byte and data byte per word; words with status bit 5 clear are dropped,
// and every third valid byte closes a packet.
// Output channel (out_valid/out_ready): a move event when either delta is
// nonzero, then one press/release event per changed button; last_event
// marks the final event of a packet.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): writes
// consumer_attached, cfg_ready always high; with it clear, bytes keep
// overwriting the same packet slot and no events come out.
// Timing: one input word per cycle while in_ready is high. The first event
// of a packet passes the descriptor queue and then the back end's output
// register, then one event per cycle while out_ready is high; a packet
// gives at most four events. Two descriptors queue between front and back;
// in_ready drops while that queue is full, when the receiver stalls or
// packets of several events come in faster than they drain.
// Reset: arst_n clears the packet slot, the buttons (all released), the
// queue and the output valid, and sets consumer_attached to 1.
`default_nettype none

module ps2_mouse_packet_decoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   status_byte,
	input  wire logic [7:0]   data_byte,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        event_kind,
	output logic signed [7:0] delta_x,
	output logic signed [8:0] delta_y,
	output logic [1:0]        button_number,
	output logic              last_event
);
	import ps2md_pkg::*;

	q_status_t q_stat;
	pkt_desc_t wr_desc;
	pkt_desc_t rd_desc;
	logic      q_push;
	logic      q_pop;

	// packet assembly
	ps2md_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.status_byte (status_byte),
		.data_byte   (data_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_desc      (wr_desc)
	);

	// descriptor queue
	ps2md_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_desc (wr_desc),
		.pop     (q_pop),
		.rd_desc (rd_desc),
		.stat    (q_stat)
	);

	// event generation
	ps2md_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_desc        (rd_desc),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.button_number (button_number),
		.last_event    (last_event)
	);

endmodule

`default_nettype wire
